// ===== rtl/led_matrix_shift_scanner_defines.svh =====
// assertion macros shared by the rtl
`ifndef LED_MATRIX_SHIFT_SCANNER_DEFINES_SVH
`define LED_MATRIX_SHIFT_SCANNER_DEFINES_SVH

`ifndef ASSERT_OFF

// property that must hold at every clock edge out of reset
`define LMS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lms assertion failed");

// condition that must never be true out of reset
`define LMS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("lms forbidden condition seen");

`else

`define LMS_ASSERT(lbl, clk, rst_n, prop)
`define LMS_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/lms_pkg.sv =====
`timescale 1ns / 1ps

package lms_pkg;

    // field widths
    localparam int COL_W     = 3;
    localparam int DWELL_W   = 16;
    localparam int PULSE_W   = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int BIT_W     = 4;
    localparam int COLUMNS   = 8;

    // register reset values and fixed words
    localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd2000;
    localparam logic [PULSE_W-1:0] PULSE_RESET = 8'd1;
    localparam logic [7:0]         BLANK_WORD  = 8'hFF;
    localparam logic [BIT_W-1:0]   LATCH_SLOT  = 4'd8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DWELL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE = 1'b1;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // word phases of one column
    typedef enum logic [1:0] {
        PH_BLANK  = 2'd0,
        PH_ROW    = 2'd1,
        PH_SELECT = 2'd2,
        PH_DWELL  = 2'd3
    } phase_t;

    // pin levels of both chains
    typedef struct packed {
        logic rd;
        logic rc;
        logic rl;
        logic cd;
        logic cc;
        logic cl;
    } pins_t;

    // one result item
    typedef struct packed {
        pins_t            pins;
        logic [COL_W-1:0] column;
        logic             wrap;
    } result_t;

endpackage

// ===== rtl/lms_sequencer.sv =====
`timescale 1ns / 1ps

module lms_sequencer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [lms_pkg::DWELL_W-1:0] dwell_ticks,
    input  logic [lms_pkg::PULSE_W-1:0] pulse_ticks,
    input  logic [7:0]                  row_byte,
    output logic [lms_pkg::COL_W-1:0]   column,
    output lms_pkg::result_t            result
);

    lms_pkg::phase_t                 phase_reg, phase_next;
    logic [lms_pkg::COL_W-1:0]       column_reg, column_next;
    logic [lms_pkg::BIT_W-1:0]       bit_reg, bit_next;
    logic [7:0]                      word_reg, word_next;
    logic [lms_pkg::DWELL_W-1:0]     count_reg, count_next;
    lms_pkg::pins_t                  pins_reg, pins_next;
    logic                            wrap_reg, wrap_next;

    logic [lms_pkg::PULSE_W-1:0]     pulse_eff;
    logic [lms_pkg::DWELL_W-1:0]     dwell_eff;
    logic [lms_pkg::DWELL_W-1:0]     count_inc;
    logic                            col_chain;
    logic                            data_bit;
    logic                            wrap_set;
    lms_pkg::pins_t                  pins_step;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= lms_pkg::PH_BLANK;
            column_reg <= '0;
            bit_reg    <= '0;
            word_reg   <= lms_pkg::BLANK_WORD;
            count_reg  <= '0;
            pins_reg   <= '0;
            wrap_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            column_reg <= column_next;
            bit_reg    <= bit_next;
            word_reg   <= word_next;
            count_reg  <= count_next;
            pins_reg   <= pins_next;
            wrap_reg   <= wrap_next;
        end
    end

    // zero register values act as one
    assign pulse_eff = (pulse_ticks == '0) ? {{(lms_pkg::PULSE_W-1){1'b0}}, 1'b1} : pulse_ticks;
    assign dwell_eff = (dwell_ticks == '0) ? {{(lms_pkg::DWELL_W-1){1'b0}}, 1'b1} : dwell_ticks;
    assign count_inc = count_reg + {{(lms_pkg::DWELL_W-1){1'b0}}, 1'b1};
    assign col_chain = (phase_reg != lms_pkg::PH_ROW);
    assign data_bit  = word_reg[3'd7 - bit_reg[2:0]];

    // one sequencer step
    always_comb
    begin
        phase_next  = phase_reg;
        column_next = column_reg;
        bit_next    = bit_reg;
        word_next   = word_reg;
        count_next  = count_reg;
        wrap_set    = 1'b0;
        pins_step   = '0;
        pins_step.rd = pins_reg.rd;
        pins_step.cd = pins_reg.cd;

        if (phase_reg == lms_pkg::PH_DWELL)
        begin
            // column lit, count the dwell
            if (count_inc >= dwell_eff)
            begin
                column_next = column_reg + 1'b1;
                wrap_set    = (column_next == '0);
                phase_next  = lms_pkg::PH_BLANK;
                bit_next    = '0;
                count_next  = '0;
                word_next   = lms_pkg::BLANK_WORD;
            end
            else
            begin
                count_next = count_inc;
            end
        end
        else
        begin
            // pin levels of the current slot
            if (count_reg == '0)
            begin
                if (bit_reg < lms_pkg::LATCH_SLOT)
                begin
                    if (col_chain)
                        pins_step.cd = data_bit;
                    else
                        pins_step.rd = data_bit;
                end
            end
            else if (bit_reg < lms_pkg::LATCH_SLOT)
            begin
                if (col_chain)
                    pins_step.cc = 1'b1;
                else
                    pins_step.rc = 1'b1;
            end
            else
            begin
                if (col_chain)
                    pins_step.cl = 1'b1;
                else
                    pins_step.rl = 1'b1;
            end

            // slot and word advance
            if (count_reg >= {{(lms_pkg::DWELL_W-lms_pkg::PULSE_W){1'b0}}, pulse_eff})
            begin
                count_next = '0;
                if (bit_reg == lms_pkg::LATCH_SLOT)
                begin
                    bit_next = '0;
                    unique case (phase_reg)
                        lms_pkg::PH_BLANK:
                        begin
                            phase_next = lms_pkg::PH_ROW;
                            word_next  = row_byte;
                        end
                        lms_pkg::PH_ROW:
                        begin
                            phase_next = lms_pkg::PH_SELECT;
                            word_next  = ~(8'd1 << column_reg);
                        end
                        default:
                        begin
                            phase_next = lms_pkg::PH_DWELL;
                        end
                    endcase
                end
                else
                begin
                    bit_next = bit_reg + 1'b1;
                end
            end
            else
            begin
                count_next = count_inc;
            end
        end

        // load items and a low step leave the sequencer where it is
        if (!step)
        begin
            phase_next  = phase_reg;
            column_next = column_reg;
            bit_next    = bit_reg;
            word_next   = word_reg;
            count_next  = count_reg;
            pins_next   = pins_reg;
            wrap_next   = wrap_reg;
        end
        else
        begin
            pins_next = pins_step;
            wrap_next = wrap_set;
        end
    end

    // result of this item
    assign column        = column_reg;
    assign result.pins   = pins_next;
    assign result.column = column_reg;
    assign result.wrap   = step & wrap_reg;

endmodule

// ===== rtl/led_matrix_shift_scanner.sv =====
`timescale 1ns / 1ps
// channel   handshake            payload
// in        in_valid / in_ready   kind, row_index, row_pattern
// out       out_valid / out_ready six pin levels, active_column, frame_wrap
// cfg       cfg_we (no wait)      cfg_index, cfg_data
//
// one item per cycle sustained while out_ready stays high
// the item register feeds the pin sequencer, whose result lands in the output register
// out_ready low holds a valid output register; an empty item register still takes one more item
// reset clears the frame store, the sequencer and the valid flags, and sets the config registers to their defaults

`include "led_matrix_shift_scanner_defines.svh"

module led_matrix_shift_scanner
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lms_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [2:0]                    row_index,
    input  logic [7:0]                    row_pattern,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          row_serial_data,
    output logic                          row_shift_clock,
    output logic                          row_latch,
    output logic                          col_serial_data,
    output logic                          col_shift_clock,
    output logic                          col_latch,
    output logic [lms_pkg::COL_W-1:0]     active_column,
    output logic                          frame_wrap
);

    logic [lms_pkg::DWELL_W-1:0] dwell_reg;
    logic [lms_pkg::PULSE_W-1:0] pulse_reg;
    logic [7:0]                  frame_reg [lms_pkg::COLUMNS];

    logic                        item_valid_reg;
    logic                        item_kind_reg;
    logic [2:0]                  item_index_reg;
    logic [7:0]                  item_pattern_reg;

    logic                        out_valid_reg;
    lms_pkg::result_t            out_reg;

    logic                        advance;
    logic                        process;
    logic                        step;
    logic [lms_pkg::COL_W-1:0]   seq_column;
    lms_pkg::result_t            seq_result;
    logic [3:0]                  pulse_pins;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_reg <= lms_pkg::DWELL_RESET;
            pulse_reg <= lms_pkg::PULSE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lms_pkg::REG_DWELL: dwell_reg <= cfg_data;
                lms_pkg::REG_PULSE: pulse_reg <= cfg_data[lms_pkg::PULSE_W-1:0];
                default:            dwell_reg <= dwell_reg;
            endcase
        end
    end

    // handshake of the two stages
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !item_valid_reg || advance;
    assign process  = item_valid_reg && advance;
    assign step     = process && (item_kind_reg == lms_pkg::KIND_TICK);

    // item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_kind_reg    <= kind;
            item_index_reg   <= row_index;
            item_pattern_reg <= row_pattern;
        end
    end

    // frame store, written by load items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lms_pkg::COLUMNS; i++)
                frame_reg[i] <= '0;
        end
        else if (process && (item_kind_reg == lms_pkg::KIND_LOAD))
        begin
            frame_reg[item_index_reg] <= item_pattern_reg;
        end
    end

    // pin sequencer
    lms_sequencer u_sequencer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .dwell_ticks (dwell_reg),
        .pulse_ticks (pulse_reg),
        .row_byte    (frame_reg[seq_column]),
        .column      (seq_column),
        .result      (seq_result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= item_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (process)
            out_reg <= seq_result;
    end

    assign out_valid       = out_valid_reg;
    assign row_serial_data = out_reg.pins.rd;
    assign row_shift_clock = out_reg.pins.rc;
    assign row_latch       = out_reg.pins.rl;
    assign col_serial_data = out_reg.pins.cd;
    assign col_shift_clock = out_reg.pins.cc;
    assign col_latch       = out_reg.pins.cl;
    assign active_column   = out_reg.column;
    assign frame_wrap      = out_reg.wrap;

    // clock and latch pins of both chains
    assign pulse_pins = {out_reg.pins.rc, out_reg.pins.rl, out_reg.pins.cc, out_reg.pins.cl};

    // checks
    `LMS_ASSERT(a_wrap_on_col0, clk, rst_n, (out_valid_reg && out_reg.wrap) |-> (out_reg.column == '0))
    `LMS_ASSERT(a_one_pulse, clk, rst_n, out_valid_reg |-> $onehot0(pulse_pins))
    `LMS_ASSERT_NEVER(a_item_lost, clk, rst_n, $past(item_valid_reg && !advance) && !item_valid_reg)

endmodule
